>>> hdl/bht_pkg.sv
`default_nettype none

package bht_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned CFG_W = 8;
	localparam int unsigned SECONDS_W = 8;
	localparam int unsigned PRESCALE_W = 7;
	localparam int unsigned MAX_BUCKETS = 8;

	localparam logic [VALUE_W-1:0] MIN_AVERAGE = VALUE_W'(25);
	localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(99);
	localparam logic [SECONDS_W-1:0] SECONDS_MAX = 8'hFF;
	localparam logic [CFG_W-1:0] HYSTERESIS_RESET = 8'd64;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_HYSTERESIS = 2'd0,
		REG_DEBOUNCE_MASK = 2'd1,
		REG_DEBOUNCE_SECONDS = 2'd2
	} reg_index_t;

	typedef enum logic {
		MODE_SAMPLE = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef struct packed {
		logic mode;
		logic [INDEX_W-1:0] bucket_index;
		logic [VALUE_W-1:0] sample_value;
		logic [VALUE_W-1:0] average_value;
	} in_word_t;

	typedef struct packed {
		logic [INDEX_W-1:0] bucket_echo;
		logic active;
		logic trigger;
		logic second_pulse;
	} out_word_t;

endpackage

`default_nettype wire

>>> hdl/bucket_hysteresis_trigger_core.sv
// Per-bucket level qualifier with hysteresis and an optional time debounce. Each word on the
// sample channel is either a bucket sample (level and running average) or one tick of the
// 100 Hz time base; each produces exactly one result word in order. One word is taken every
// clock cycle when the result side keeps up: a word is registered at the input, evaluated
// against the bucket state by two 16x9 threshold multiplies and compares, and is then
// stored in the result register. Configuration registers (hysteresis at 0x0, debounce mask
// at 0x4, debounce seconds at 0x8) should be written only while no words are in flight.
`default_nettype none

module bucket_hysteresis_trigger_core #(
	parameter int unsigned NUM_BUCKETS = 8
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic sample_valid,
	output logic sample_ready,
	input wire bht_pkg::in_word_t sample,

	output logic result_valid,
	input wire logic result_ready,
	output bht_pkg::out_word_t result,

	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [bht_pkg::PADDR_W-1:0] paddr,
	input wire logic [bht_pkg::PDATA_W-1:0] pwdata,
	output logic [bht_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	localparam int unsigned PROD_W = bht_pkg::VALUE_W + bht_pkg::CFG_W + 1;
	localparam int unsigned THR_W = bht_pkg::VALUE_W + 1;

	logic [bht_pkg::CFG_W-1:0] hysteresis_q;
	logic [bht_pkg::CFG_W-1:0] debounce_mask_q;
	logic [bht_pkg::CFG_W-1:0] debounce_seconds_q;

	logic active_q [NUM_BUCKETS];
	logic [bht_pkg::SECONDS_W-1:0] seconds_q [NUM_BUCKETS];
	logic [bht_pkg::PRESCALE_W-1:0] prescaler_q;

	bht_pkg::in_word_t word_s1;
	logic valid_s1;
	bht_pkg::out_word_t result_q;
	logic result_valid_q;

	logic advance;
	logic cfg_write;
	bht_pkg::reg_index_t cfg_index;

	logic is_tick;
	logic index_ok;
	logic [NUM_BUCKETS-1:0] hit;
	logic cur_active;
	logic [bht_pkg::SECONDS_W-1:0] cur_seconds;
	logic [PROD_W-1:0] prod_hi;
	logic [PROD_W-1:0] prod_lo;
	logic [THR_W-1:0] thr_hi;
	logic [THR_W-1:0] thr_lo;
	logic [THR_W-1:0] level;
	logic gated;
	logic rise;
	logic drop;
	logic next_active;
	logic wrap;
	bht_pkg::out_word_t result_d;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_index = bht_pkg::reg_index_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hysteresis_q <= bht_pkg::HYSTERESIS_RESET;
			debounce_mask_q <= '0;
			debounce_seconds_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bht_pkg::REG_HYSTERESIS: hysteresis_q <= pwdata[bht_pkg::CFG_W-1:0];
				bht_pkg::REG_DEBOUNCE_MASK: debounce_mask_q <= pwdata[bht_pkg::CFG_W-1:0];
				bht_pkg::REG_DEBOUNCE_SECONDS: begin
					debounce_seconds_q <= pwdata[bht_pkg::CFG_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_index)
			bht_pkg::REG_HYSTERESIS: prdata = bht_pkg::PDATA_W'(hysteresis_q);
			bht_pkg::REG_DEBOUNCE_MASK: prdata = bht_pkg::PDATA_W'(debounce_mask_q);
			bht_pkg::REG_DEBOUNCE_SECONDS: prdata = bht_pkg::PDATA_W'(debounce_seconds_q);
			default: prdata = '0;
		endcase
	end

	assign advance = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			word_s1 <= sample;
		end
	end

	assign is_tick = (word_s1.mode == bht_pkg::MODE_TICK);
	assign index_ok = {1'b0, word_s1.bucket_index} < (bht_pkg::INDEX_W + 1)'(NUM_BUCKETS);

	always_comb begin
		cur_active = 1'b0;
		cur_seconds = '0;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			hit[i] = !is_tick && (word_s1.bucket_index == bht_pkg::INDEX_W'(i));
			cur_active = cur_active | (hit[i] & active_q[i]);
			cur_seconds = cur_seconds | ({bht_pkg::SECONDS_W{hit[i]}} & seconds_q[i]);
		end
	end

	assign prod_hi = PROD_W'(word_s1.average_value) * PROD_W'({1'b0, hysteresis_q} + 9'd256);
	assign prod_lo = PROD_W'(word_s1.average_value) * PROD_W'(9'd256 - {1'b0, hysteresis_q});
	assign thr_hi = prod_hi[PROD_W-1:8];
	assign thr_lo = prod_lo[PROD_W-1:8];
	assign level = {1'b0, word_s1.sample_value};

	assign gated = debounce_mask_q[word_s1.bucket_index];
	assign rise = !cur_active && (word_s1.average_value > bht_pkg::MIN_AVERAGE)
		&& (level > thr_hi) && (!gated || (cur_seconds >= debounce_seconds_q));
	assign drop = cur_active && ((level < thr_lo)
		|| (word_s1.average_value < bht_pkg::MIN_AVERAGE));
	assign next_active = cur_active ? !drop : rise;
	assign wrap = is_tick && (prescaler_q == bht_pkg::PRESCALE_LAST);

	always_comb begin
		result_d = '0;
		if (is_tick) begin
			result_d.second_pulse = wrap;
		end else begin
			result_d.bucket_echo = word_s1.bucket_index;
			result_d.active = index_ok && next_active;
			result_d.trigger = index_ok && rise;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				active_q[i] <= 1'b0;
				seconds_q[i] <= '0;
			end
		end else if (advance) begin
			if (is_tick) begin
				prescaler_q <= wrap ? '0 : prescaler_q + 1'b1;
				if (wrap) begin
					for (int i = 0; i < NUM_BUCKETS; i++) begin
						if (seconds_q[i] != bht_pkg::SECONDS_MAX) begin
							seconds_q[i] <= seconds_q[i] + 1'b1;
						end
					end
				end
			end else begin
				for (int i = 0; i < NUM_BUCKETS; i++) begin
					if (hit[i]) begin
						active_q[i] <= next_active;
						if (rise) begin
							seconds_q[i] <= '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// A rise always leaves the bucket active.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.trigger |-> result_q.active)
		else $error("trigger without active bucket");

	// A tick result carries no bucket information.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.second_pulse |->
			!result_q.active && !result_q.trigger && (result_q.bucket_echo == '0))
		else $error("second pulse mixed with bucket result");

	// The prescaler never leaves its modulo-100 range.
	assert property (@(posedge clk) disable iff (!arst_n)
		prescaler_q <= bht_pkg::PRESCALE_LAST)
		else $error("prescaler out of range");

	// A result word waiting for the consumer is not overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |=> result_valid_q && $stable(result_q))
		else $error("stalled result word changed");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned NUM_BUCKETS = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned TICK_RUN_WORDS = 140;
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	typedef enum int {
		SHAPE_ABOVE,
		SHAPE_BELOW,
		SHAPE_BETWEEN,
		SHAPE_AT_HIGH,
		SHAPE_AT_LOW,
		SHAPE_ANY
	} sample_shape_t;

	class level_scoreboard;
		logic [bht_pkg::CFG_W-1:0] hysteresis;
		logic [bht_pkg::CFG_W-1:0] debounce_mask;
		logic [bht_pkg::CFG_W-1:0] debounce_seconds;
		bit bucket_on [bht_pkg::MAX_BUCKETS];
		bit [bht_pkg::SECONDS_W-1:0] bucket_seconds [bht_pkg::MAX_BUCKETS];
		bit [bht_pkg::PRESCALE_W-1:0] prescale;
		int unsigned bucket_count;
		bht_pkg::out_word_t expected_q [$];
		int unsigned words_in;
		int unsigned results_checked;
		int unsigned triggers;
		int unsigned pulses;
		int unsigned mismatches;

		function new(int unsigned count);
			bucket_count = count;
			hysteresis = bht_pkg::HYSTERESIS_RESET;
			debounce_mask = '0;
			debounce_seconds = '0;
			prescale = '0;
			for (int i = 0; i < bht_pkg::MAX_BUCKETS; i++) begin
				bucket_on[i] = 1'b0;
				bucket_seconds[i] = '0;
			end
		endfunction

		function void write_reg(logic [1:0] index, logic [bht_pkg::CFG_W-1:0] value);
			case (index)
				bht_pkg::REG_HYSTERESIS: hysteresis = value;
				bht_pkg::REG_DEBOUNCE_MASK: debounce_mask = value;
				bht_pkg::REG_DEBOUNCE_SECONDS: debounce_seconds = value;
				default: ;
			endcase
		endfunction

		function bit [16:0] scaled_average(bit [bht_pkg::VALUE_W-1:0] average,
				bit [8:0] factor);
			bit [24:0] product;
			product = 25'(average) * 25'(factor);
			return product[24:8];
		endfunction

		function bit [16:0] high_threshold(bit [bht_pkg::VALUE_W-1:0] average);
			return scaled_average(average, 9'd256 + {1'b0, hysteresis});
		endfunction

		function bit [16:0] low_threshold(bit [bht_pkg::VALUE_W-1:0] average);
			return scaled_average(average, 9'd256 - {1'b0, hysteresis});
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_input(bht_pkg::in_word_t w);
			bht_pkg::out_word_t e;
			bit [16:0] hi;
			bit [16:0] lo;
			bit gated;
			int unsigned b;
			e = '0;
			words_in++;
			if (w.mode == bht_pkg::MODE_TICK) begin
				if (prescale == bht_pkg::PRESCALE_LAST) begin
					prescale = '0;
					e.second_pulse = 1'b1;
					for (int i = 0; i < bucket_count; i++) begin
						if (bucket_seconds[i] != bht_pkg::SECONDS_MAX)
							bucket_seconds[i]++;
					end
				end else begin
					prescale++;
				end
			end else begin
				e.bucket_echo = w.bucket_index;
				b = int'(w.bucket_index);
				if (b < bucket_count) begin
					hi = high_threshold(w.average_value);
					lo = low_threshold(w.average_value);
					gated = debounce_mask[b];
					if (bucket_on[b]) begin
						if (17'(w.sample_value) < lo
								|| w.average_value < bht_pkg::MIN_AVERAGE)
							bucket_on[b] = 1'b0;
					end else if (w.average_value > bht_pkg::MIN_AVERAGE
							&& 17'(w.sample_value) > hi
							&& (!gated || bucket_seconds[b] >= debounce_seconds)) begin
						bucket_on[b] = 1'b1;
						bucket_seconds[b] = '0;
						e.trigger = 1'b1;
					end
					e.active = bucket_on[b];
				end
			end
			expected_q.push_back(e);
		endfunction

		function void check_result(bht_pkg::out_word_t r);
			bht_pkg::out_word_t e;
			if (expected_q.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("tb_top: unexpected word: echo=%0d act=%0b trg=%0b sec=%0b",
						r.bucket_echo, r.active, r.trigger, r.second_pulse);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			results_checked++;
			if (e.trigger)
				triggers++;
			if (e.second_pulse)
				pulses++;
			if (r.bucket_echo !== e.bucket_echo || r.active !== e.active ||
					r.trigger !== e.trigger || r.second_pulse !== e.second_pulse) begin
				if (mismatches < MAX_REPORTS)
					$display("tb_top: mismatch at %0t (exp/got): echo %0d/%0d act %0b/%0b",
						$time, e.bucket_echo, r.bucket_echo, e.active, r.active,
						" trg %0b/%0b pulse %0b/%0b",
						e.trigger, r.trigger, e.second_pulse, r.second_pulse);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	bht_pkg::in_word_t sample;
	logic result_valid;
	logic result_ready = 1'b0;
	bht_pkg::out_word_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [bht_pkg::PADDR_W-1:0] paddr;
	logic [bht_pkg::PDATA_W-1:0] pwdata;
	logic [bht_pkg::PDATA_W-1:0] prdata;
	logic pready;

	level_scoreboard sb;
	bit steady_flow;
	int unsigned ready_hold = 0;
	int unsigned stall_cycles = 0;

	bucket_hysteresis_trigger_core #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (steady_flow) begin
			result_ready <= 1'b1;
			ready_hold = 0;
		end else if (ready_hold != 0) begin
			ready_hold--;
		end else begin
			ready_hold = pick_gap();
			result_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: watchdog expired with %0d result words outstanding",
					sb.pending());
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	function automatic bht_pkg::in_word_t sample_word(logic [bht_pkg::INDEX_W-1:0] bucket,
			logic [bht_pkg::VALUE_W-1:0] level, logic [bht_pkg::VALUE_W-1:0] average);
		bht_pkg::in_word_t w;
		w.mode = bht_pkg::MODE_SAMPLE;
		w.bucket_index = bucket;
		w.sample_value = level;
		w.average_value = average;
		return w;
	endfunction

	function automatic bht_pkg::in_word_t tick_word();
		bht_pkg::in_word_t w;
		w.mode = bht_pkg::MODE_TICK;
		w.bucket_index = bht_pkg::INDEX_W'($urandom);
		w.sample_value = bht_pkg::VALUE_W'($urandom);
		w.average_value = bht_pkg::VALUE_W'($urandom);
		return w;
	endfunction

	function automatic bht_pkg::in_word_t random_sample();
		sample_shape_t shape;
		int unsigned r;
		int unsigned average;
		int unsigned hi;
		int unsigned lo;
		int unsigned top;
		int unsigned upper;
		int unsigned level;
		int unsigned min_avg;
		min_avg = int'(bht_pkg::MIN_AVERAGE);
		r = $urandom_range(0, 99);
		if (r < 30)
			shape = SHAPE_ABOVE;
		else if (r < 55)
			shape = SHAPE_BELOW;
		else if (r < 70)
			shape = SHAPE_BETWEEN;
		else if (r < 77)
			shape = SHAPE_AT_HIGH;
		else if (r < 84)
			shape = SHAPE_AT_LOW;
		else
			shape = SHAPE_ANY;
		if (shape == SHAPE_ANY)
			return sample_word(bht_pkg::INDEX_W'($urandom), bht_pkg::VALUE_W'($urandom),
				bht_pkg::VALUE_W'($urandom));
		r = $urandom_range(0, 9);
		if (r == 0)
			average = min_avg;
		else if (r == 1)
			average = $urandom_range(0, min_avg - 1);
		else if (r == 2)
			average = $urandom_range(60000, 65535);
		else
			average = $urandom_range(min_avg + 1, 4000);
		hi = int'(sb.high_threshold(bht_pkg::VALUE_W'(average)));
		lo = int'(sb.low_threshold(bht_pkg::VALUE_W'(average)));
		top = (hi > 65535) ? 65535 : hi;
		case (shape)
			SHAPE_ABOVE: begin
				if (hi >= 65535) begin
					level = 65535;
				end else begin
					upper = hi + 1 + average / 4;
					if (upper > 65535)
						upper = 65535;
					level = $urandom_range(upper, hi + 1);
				end
			end
			SHAPE_BELOW: level = (lo == 0) ? 0 : $urandom_range(lo - 1, (lo > 64) ? lo - 64 : 0);
			SHAPE_BETWEEN: level = $urandom_range(top, lo);
			SHAPE_AT_HIGH: level = top;
			default: level = lo;
		endcase
		return sample_word(bht_pkg::INDEX_W'($urandom_range(0, NUM_BUCKETS - 1)),
			bht_pkg::VALUE_W'(level), bht_pkg::VALUE_W'(average));
	endfunction

	task automatic send_word(bht_pkg::in_word_t w);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= w;
		do
			@(posedge clk);
		while (!sample_ready);
		sb.note_input(w);
	endtask

	task automatic run_random(int unsigned count, int unsigned tick_pct);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_word(tick_word());
			else
				send_word(random_sample());
		end
	endtask

	task automatic idle_wait();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] index, logic [bht_pkg::CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= bht_pkg::PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.write_reg(index, value);
	endtask

	task automatic set_config(logic [bht_pkg::CFG_W-1:0] hyst,
			logic [bht_pkg::CFG_W-1:0] mask, logic [bht_pkg::CFG_W-1:0] seconds,
			bit poke_unmapped);
		idle_wait();
		reg_write(bht_pkg::REG_HYSTERESIS, hyst);
		reg_write(bht_pkg::REG_DEBOUNCE_MASK, mask);
		reg_write(bht_pkg::REG_DEBOUNCE_SECONDS, seconds);
		if (poke_unmapped)
			reg_write(REG_UNMAPPED, 8'h3C);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		sb = new(NUM_BUCKETS);
		steady_flow = 1'b0;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Default thresholds at an average of 1000 are 750 and 1250.
		send_word(sample_word(3'd0, 16'd2000, 16'd1000));
		send_word(sample_word(3'd0, 16'd750, 16'd1000));
		send_word(sample_word(3'd0, 16'd749, 16'd1000));
		send_word(sample_word(3'd1, 16'hFFFF, bht_pkg::MIN_AVERAGE));
		send_word(sample_word(3'd1, 16'hFFFF, bht_pkg::MIN_AVERAGE + 1));
		send_word(sample_word(3'd1, 16'd30, bht_pkg::MIN_AVERAGE));
		send_word(sample_word(3'd1, 16'hFFFF, bht_pkg::MIN_AVERAGE - 1));
		send_word(sample_word(3'd2, 16'hFFFF, 16'hFFFF));
		send_word(sample_word(3'd3, 16'd0, 16'd0));
		send_word(tick_word());
		send_word(sample_word(3'd7, 16'd1250, 16'd1000));
		send_word(sample_word(3'd7, 16'd1251, 16'd1000));
		send_word(sample_word(3'd4, 16'hFFFF, 16'd100));
		send_word(sample_word(3'd5, 16'h5555, 16'h2AAA));
		send_word(sample_word(3'd6, 16'hAAAA, 16'h5555));
		send_word(sample_word(3'd6, 16'd0, 16'h5555));
		send_word(tick_word());
		send_word(sample_word(3'd4, 16'd0, 16'hFFFF));

		run_random(90, 30);

		set_config(8'd0, 8'hFF, 8'd0, 1'b1);
		run_random(60, 40);

		set_config(8'd255, 8'hA5, 8'd1, 1'b0);
		run_random(40, 60);
		steady_flow = 1'b1;
		run_random(40, 60);
		steady_flow = 1'b0;

		set_config(8'd128, 8'h5A, 8'd2, 1'b0);
		run_random(60, 70);

		// Tick-heavy run so that the prescaler wraps and gated rises wait for seconds.
		set_config(bht_pkg::HYSTERESIS_RESET, 8'hFF, 8'd1, 1'b0);
		steady_flow = 1'b1;
		run_random(TICK_RUN_WORDS, 90);
		steady_flow = 1'b0;

		set_config(bht_pkg::HYSTERESIS_RESET, 8'h00, 8'h00, 1'b0);
		run_random(50, 20);

		idle_wait();
		repeat (8) @(posedge clk);
		$display("tb_top: %0d words sent, %0d results checked, %0d triggers, %0d second pulses",
			sb.words_in, sb.results_checked, sb.triggers, sb.pulses);
		$display("tb_top: hysteresis 0..255, debounce gating and wraps, %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/bht_pkg.sv
hdl/bucket_hysteresis_trigger_core.sv
bench/tb_top.sv
